// File: src/ouvl_pkg.sv
// Shared types and constants for the ordered unique value list.
// Holds the transfer payload structs, status codes, controller states and
// the command and status groups between the controller and the datapath.
package ouvl_pkg;

    localparam int CMD_W = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

    typedef enum logic [ST_W-1:0] {
        ST_PUSHED     = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_FULL       = 3'd2,
        ST_REMOVED    = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_CLEAR_ZERO = 3'd6
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic imm;
        logic go_shift;
        logic search_end;
        logic shift_done;
        logic out_free;
    } t_dp_stat;

endpackage

// File: src/ordered_unique_value_list.sv
// Ordered unique value list: keeps up to DEPTH distinct nonzero values in
// insertion order. Push appends a value unless it is zero, already present,
// or the list is full; remove finds a value and shifts later entries down;
// clear (command with the high bit set) empties the list.
// Channels: the input channel moves one command per transfer (i_valid,
// o_stall, i_in); the output channel moves one result per command (o_valid,
// i_stall, o_out) with a status, the position involved and the new count.
// Steps per command, from the input transfer through the output load: a
// clear, a zero value, a push to a full list, a remove from an empty list and
// a push into an empty list go straight to the output load. A search first
// primes the read port, then compares one entry per cycle until a match or
// the last entry; after a removal the block closes the gap one entry per
// cycle. The next command is taken the cycle after the load.
// One command is worked on at a time. The output register lets the next
// command be taken while a result waits; if the receiver keeps stalling, the
// block finishes that command and then holds it, stalling its input.
// Reset empties the list and the output register; no clearing pass is needed.
module ordered_unique_value_list
    import ouvl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller sequences each command: accept, scan, close the gap,
    // then hand the result to the output register when it is free.
    ouvl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_stall (o_stall)
    );

    // The datapath holds the entries, the count and the registered result.
    ouvl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stall (i_stall),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule

// File: src/ouvl_ctrl.sv
// Controller state machine of the ordered unique value list.
// Depends on ouvl_pkg for the state enum and the command and status structs.
module ouvl_ctrl
    import ouvl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_stall
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_stat.imm ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.go_shift) begin
                    n_state = S_SHIFT;
                end else if (i_stat.search_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_stall      = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
            end
            S_DONE: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // A finished result that cannot leave yet keeps the controller waiting.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !i_stat.out_free |=> (r_state == S_DONE))
        else $error("controller left DONE while the output register was busy");

    // Every emitted result returns the controller to idle.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after a result");

endmodule

// File: src/ouvl_datapath.sv
// Datapath of the ordered unique value list: entry memory, scan counter,
// compare, count and output register. Depends on ouvl_pkg.
module ouvl_datapath
    import ouvl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  logic      i_stall,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_valid,
    output t_out_item o_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    logic [VAL_W-1:0] r_value,    n_value;
    logic             r_push,     n_push;
    logic [IW-1:0]    r_scan,     n_scan;
    logic [IW-1:0]    r_data_pos, n_data_pos;
    logic             r_data_vld, n_data_vld;
    logic [CW-1:0]    r_count,    n_count;
    t_status          r_res_status, n_res_status;
    logic [IW-1:0]    r_res_pos,  n_res_pos;
    logic             r_out_vld,  n_out_vld;
    t_out_item        r_out,      n_out;

    logic             in_clear;
    logic             in_zero;
    logic             in_push;
    logic             full;
    logic             empty;
    logic [CW-1:0]    pos_plus1;
    logic             last;
    logic             hit;
    logic             miss_done;
    logic [IW-1:0]    scan_next;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    assign in_clear  = i_in.command[1];
    assign in_zero   = (i_in.value == '0);
    assign in_push   = (i_in.command == CMD_PUSH);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign pos_plus1 = CW'(r_data_pos) + CW'(1);
    assign last      = (pos_plus1 == r_count);
    assign hit       = r_data_vld && (r_rd_data == r_value);
    assign miss_done = r_data_vld && !hit && last;
    // The read address walks up to the last valid entry and then holds there.
    assign scan_next = ((CW'(r_scan) + CW'(1)) < r_count) ? (r_scan + IW'(1)) : r_scan;

    always_comb begin
        o_stat.imm        = in_clear || in_zero || empty || (in_push && full);
        o_stat.go_shift   = hit && !r_push && !last;
        o_stat.search_end = hit || miss_done;
        o_stat.shift_done = r_data_vld && last;
        o_stat.out_free   = !r_out_vld || !i_stall;
    end

    // Single write port: first push into an empty list, append after a miss,
    // or one step of closing the gap after a removal.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rd_data;
        if (i_cmd.load && in_push && !in_clear && !in_zero && empty) begin
            wr_en   = 1'b1;
            wr_data = i_in.value;
        end else if (i_cmd.search && miss_done && r_push) begin
            wr_en   = 1'b1;
            wr_addr = IW'(r_count);
            wr_data = r_value;
        end else if (i_cmd.shift && r_data_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_data_pos - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_scan];
    end

    always_comb begin
        n_value      = r_value;
        n_push       = r_push;
        n_scan       = r_scan;
        n_data_pos   = r_data_pos;
        n_data_vld   = r_data_vld;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        if (i_cmd.load) begin
            n_value      = i_in.value;
            n_push       = in_push;
            n_scan       = '0;
            n_data_vld   = 1'b0;
            n_res_pos    = '0;
            n_res_status = ST_CLEAR_ZERO;
            if (in_clear) begin
                n_count = '0;
            end else if (in_zero) begin
                n_res_status = ST_CLEAR_ZERO;
            end else if (in_push) begin
                if (full) begin
                    n_res_status = ST_FULL;
                end else if (empty) begin
                    n_res_status = ST_PUSHED;
                    n_count      = CW'(1);
                end
            end else if (empty) begin
                n_res_status = ST_EMPTY;
            end
        end else if (i_cmd.search) begin
            if (hit) begin
                n_res_pos = r_data_pos;
                if (r_push) begin
                    n_res_status = ST_DUPLICATE;
                end else begin
                    n_res_status = ST_REMOVED;
                    if (last) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_scan     = r_data_pos + IW'(1);
                        n_data_vld = 1'b0;
                    end
                end
            end else if (miss_done) begin
                if (r_push) begin
                    n_res_status = ST_PUSHED;
                    n_res_pos    = IW'(r_count);
                    n_count      = r_count + CW'(1);
                end else begin
                    n_res_status = ST_NOT_FOUND;
                end
            end else begin
                n_data_vld = 1'b1;
                n_data_pos = r_scan;
                n_scan     = scan_next;
            end
        end else if (i_cmd.shift) begin
            if (r_data_vld && last) begin
                n_count = r_count - CW'(1);
            end else begin
                n_data_vld = 1'b1;
                n_data_pos = r_scan;
                n_scan     = scan_next;
            end
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (i_cmd.emit) begin
            n_out_vld         = 1'b1;
            n_out.status      = r_res_status;
            n_out.position    = POS_W'(r_res_pos);
            n_out.entry_count = CNT_W'(r_count);
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_data_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_data_vld <= n_data_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_push       <= n_push;
        r_scan       <= n_scan;
        r_data_pos   <= n_data_pos;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_out        <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds the list depth");

    // Only entries below the count are ever compared or moved.
    a_pos_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_vld && (i_cmd.search || i_cmd.shift) |-> (CW'(r_data_pos) < r_count))
        else $error("scan reached an entry beyond the count");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_vld)
        else $error("emitted result did not reach the output register");

endmodule
